// ===== src/mma_pkg.sv =====
// Package for the multichannel moving average block.
// Holds sizes, controller states, the controller/datapath command and status
// structs and the window clamp function. No dependencies.
package mma_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int NUM_CHANNELS = 6;
  localparam int NUM_WIN_REGS = 6;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 10;
  localparam int WIN_W    = 6;
  localparam int CFG_IW   = 3;

  localparam int AVG_MAX    = (1 << SAMPLE_W) - 1;
  localparam int WIN_RESET  = 32;
  localparam int CH_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EW_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = $clog2(MAX_WINDOW * AVG_MAX + 1);
  localparam int RING_DEPTH = NUM_CHANNELS * MAX_WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DIV_CW     = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               load_in;
    logic               clear;
    logic [RING_AW-1:0] clr_addr;
    logic               rd_ring;
    logic               update;
    logic               div_step;
    logic               load_out;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic out_busy;
  } status_t;

  // register value 0 acts as 1, values above MAX_WINDOW clamp
  function automatic logic [EW_W-1:0] eff_window(input logic [WIN_W-1:0] reg_val);
    logic [EW_W-1:0] res;
    if (reg_val == '0) begin
      res = EW_W'(1);
    end else if (int'(reg_val) > MAX_WINDOW) begin
      res = EW_W'(MAX_WINDOW);
    end else begin
      res = EW_W'(reg_val);
    end
    return res;
  endfunction

endpackage

// ===== src/multichannel_moving_average.sv =====
// Six-channel boxcar moving average, top level. Ties the controller and the
// datapath together. Depends on mma_pkg, mma_ctrl and mma_dp.
//
// Each word names a channel (0..5) and carries a 10-bit sample; the block
// returns one word per input with the channel echoed, the truncated average
// of that channel's last window_chN samples (register 0 acts as 1, above 32
// clamps to 32) and an accepted flag. Channels 6 and 7 change nothing and
// return average 0, accepted 0. Items are handled one at a time: a valid
// channel goes through a ring memory read, an update step, the bit-serial
// divider and a load into the output register before the next word is
// accepted; an invalid channel skips the update and the divider. The output
// register lets the next word be taken while a result waits. After reset a
// pass zeroes the sample ring, with input stalled; window writes are
// taken during it. Write windows only while the block is idle.
module multichannel_moving_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mma_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [mma_pkg::WIN_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mma_pkg::CH_W-1:0]     channel_i,
  input  logic [mma_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mma_pkg::CH_W-1:0]     out_channel_o,
  output logic [mma_pkg::SAMPLE_W-1:0] average_o,
  output logic                         accepted_o
);
  import mma_pkg::*;

  cmd_t    cmd;
  status_t status;

  mma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mma_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_channel_o (out_channel_o),
    .average_o     (average_o),
    .accepted_o    (accepted_o)
  );

endmodule

// ===== src/mma_ctrl.sv =====
// Controller for the moving average: sequences clear sweep, ring read,
// update, bit-serial divide and output load. Depends on mma_pkg.
module mma_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mma_pkg::status_t status_i,
  output mma_pkg::cmd_t   cmd_o,
  output logic            in_stall_o
);
  import mma_pkg::*;

  state_e              state_q, state_d;
  logic [RING_AW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [DIV_CW-1:0]   div_cnt_q, div_cnt_d;
  logic                clr_last, div_last;

  assign clr_last = (clr_cnt_q == RING_AW'(RING_DEPTH - 1));
  assign div_last = (div_cnt_q == DIV_CW'(SUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + RING_AW'(1);
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = status_i.ch_ok ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q + DIV_CW'(1);
        if (div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd_ring = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== src/mma_dp.sv =====
// Datapath for the moving average: window registers, sample ring memory,
// per-channel sums and pointers, restoring divider and output register.
// Depends on mma_pkg.
module mma_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mma_pkg::cmd_t                cmd_i,
  output mma_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [mma_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [mma_pkg::WIN_W-1:0]    cfg_wdata_i,
  input  logic [mma_pkg::CH_W-1:0]     channel_i,
  input  logic [mma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [mma_pkg::CH_W-1:0]     out_channel_o,
  output logic [mma_pkg::SAMPLE_W-1:0] average_o,
  output logic                         accepted_o
);
  import mma_pkg::*;

  logic [WIN_W-1:0]    win_q [NUM_WIN_REGS];
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] ring_rd_q;
  logic [SUM_W-1:0]    sum_q [NUM_CHANNELS];
  logic [PTR_W-1:0]    ptr_q [NUM_CHANNELS];

  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [EW_W-1:0]     rem_q, rem_d;

  logic                out_valid_q;
  logic [CH_W-1:0]     out_ch_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_acc_q;

  logic                ch_ok;
  logic [CH_AW-1:0]    ch_idx;
  logic [EW_W-1:0]     win_eff;
  logic [RING_AW-1:0]  ring_addr;
  logic [SUM_W-1:0]    sum_new;
  logic [EW_W:0]       ptr_inc;
  logic [PTR_W-1:0]    ptr_next;
  logic [EW_W:0]       div_t;
  logic [EW_W:0]       div_diff;
  logic                div_ge;
  logic [SAMPLE_W-1:0] avg_sat;

  assign ch_ok   = (int'(ch_q) < NUM_CHANNELS) && (int'(ch_q) < NUM_WIN_REGS);
  assign ch_idx  = ch_q[CH_AW-1:0];
  assign win_eff = eff_window(win_q[ch_q]);

  assign ring_addr = RING_AW'(ch_idx) * RING_AW'(MAX_WINDOW) + RING_AW'(ptr_q[ch_idx]);

  // exact: the sum always equals the ring contents, so no wrap
  assign sum_new = sum_q[ch_idx] - SUM_W'(ring_rd_q) + SUM_W'(smp_q);

  assign ptr_inc  = (EW_W+1)'(ptr_q[ch_idx]) + (EW_W+1)'(1);
  assign ptr_next = (ptr_inc >= (EW_W+1)'(win_eff)) ? '0 : ptr_inc[PTR_W-1:0];

  // one quotient bit per step, MSB first
  assign div_t    = {rem_q, quo_q[SUM_W-1]};
  assign div_diff = div_t - (EW_W+1)'(win_eff);
  assign div_ge   = (div_t >= (EW_W+1)'(win_eff));

  assign avg_sat = (quo_q > SUM_W'(AVG_MAX)) ? SAMPLE_W'(AVG_MAX) : quo_q[SAMPLE_W-1:0];

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.update) begin
      quo_d = sum_new;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[SUM_W-2:0], div_ge};
      rem_d = div_ge ? div_diff[EW_W-1:0] : div_t[EW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WIN_REGS; i++) begin
        win_q[i] <= WIN_W'(WIN_RESET);
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_q[i] <= '0;
        ptr_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (int'(cfg_index_i) < NUM_WIN_REGS)) begin
        win_q[cfg_index_i] <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        sum_q[ch_idx] <= sum_new;
        ptr_q[ch_idx] <= ptr_next;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample ring: one write port (clear sweep or update), one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      ring_mem[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.update) begin
      ring_mem[ring_addr] <= smp_q;
    end
    if (cmd_i.rd_ring) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q  <= channel_i;
      smp_q <= sample_i;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.load_out) begin
      out_ch_q  <= ch_q;
      out_avg_q <= ch_ok ? avg_sat : '0;
      out_acc_q <= ch_ok;
    end
  end

  assign status_o.ch_ok    = ch_ok;
  assign status_o.out_busy = out_valid_q & out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign average_o     = out_avg_q;
  assign accepted_o    = out_acc_q;

endmodule

// ===== verif/testbench.sv =====
// Testbench for multichannel_moving_average: drives channel/sample words,
// predicts each channel's boxcar average and checks every output word.
// Depends on mma_pkg and the multichannel_moving_average RTL.
module testbench;
  import mma_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_WORDS  = 140;
  localparam int MAX_PRINTED  = 50;

  localparam logic [CH_W-1:0] CH_UNUSED_6 = 3'd6;
  localparam logic [CH_W-1:0] CH_UNUSED_7 = 3'd7;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIN_CH0,
    REG_WIN_CH1,
    REG_WIN_CH2,
    REG_WIN_CH3,
    REG_WIN_CH4,
    REG_WIN_CH5,
    REG_SPARE_6,
    REG_SPARE_7
  } win_reg_e;

  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] avg;
    logic                acc;
  } avg_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_index_i;
  logic [WIN_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CH_W-1:0]     channel_i;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CH_W-1:0]     out_channel_o;
  logic [SAMPLE_W-1:0] average_o;
  logic                accepted_o;

  // predictor state
  logic [WIN_W-1:0]    win_reg [NUM_WIN_REGS];
  logic [SAMPLE_W-1:0] hist [NUM_CHANNELS][MAX_WINDOW];
  int                  ch_sum [NUM_CHANNELS];
  int                  wr_ptr [NUM_CHANNELS];

  avg_word_t expected_avg_q[$];
  int        errors;
  int        cycle_cnt;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        hold_pending;

  multichannel_moving_average i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_channel_o(out_channel_o),
    .average_o    (average_o),
    .accepted_o   (accepted_o)
  );

  always #10 clk_i = ~clk_i;

  // Update one channel's ring and sum; returns the word the block should emit.
  function automatic avg_word_t boxcar_update(input logic [CH_W-1:0] ch,
                                              input logic [SAMPLE_W-1:0] smp);
    avg_word_t res;
    int        win;
    int        slot;
    int        quot;
    res.ch  = ch;
    res.avg = '0;
    res.acc = 1'b0;
    if (ch < NUM_CHANNELS) begin
      if (win_reg[ch] == '0) begin
        win = 1;
      end else if (int'(win_reg[ch]) > MAX_WINDOW) begin
        win = MAX_WINDOW;
      end else begin
        win = int'(win_reg[ch]);
      end
      // pointer is used as stored, even past a freshly shrunk window
      slot = wr_ptr[ch];
      ch_sum[ch] = ch_sum[ch] - int'(hist[ch][slot]) + int'(smp);
      hist[ch][slot] = smp;
      quot = ch_sum[ch] / win;
      res.avg = (quot > AVG_MAX) ? SAMPLE_W'(AVG_MAX) : SAMPLE_W'(quot);
      res.acc = 1'b1;
      slot++;
      if (slot >= win) begin
        slot = 0;
      end
      wr_ptr[ch] = slot;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTED) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    expected_avg_q.push_back(boxcar_update(ch, smp));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_avg_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input win_reg_e idx, input logic [WIN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx < NUM_WIN_REGS) begin
      win_reg[idx] = val;
    end
  endtask

  task automatic test_reset_defaults();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_word(3'd0, 10'd1023);
    send_word(3'd0, 10'd0);
    send_word(3'd5, 10'h2AA);
    send_word(3'd5, 10'h155);
    send_word(CH_UNUSED_6, 10'd1023);
    send_word(CH_UNUSED_7, 10'd0);
    send_word(3'd1, 10'd1023);
    wait_idle();
  endtask

  // zero acts as one, above MAX_WINDOW clamps, spare indexes are dropped
  task automatic test_window_regs();
    write_window(REG_WIN_CH0, 6'd0);
    write_window(REG_WIN_CH1, 6'd1);
    write_window(REG_WIN_CH2, 6'd63);
    write_window(REG_WIN_CH3, 6'd33);
    write_window(REG_WIN_CH4, 6'd32);
    write_window(REG_WIN_CH5, 6'd21);
    write_window(REG_SPARE_6, 6'd42);
    write_window(REG_SPARE_7, 6'd63);
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      send_word(CH_W'(ch), SAMPLE_W'(100 * ch + 7));
    end
    send_word(3'd1, 10'd1023);
    send_word(3'd0, 10'd512);
    wait_idle();
  endtask

  // shrink a partly filled window: pointer past the end, stale sum saturates average
  task automatic test_window_shrink();
    write_window(REG_WIN_CH2, 6'd8);
    repeat (6) send_word(3'd2, 10'd1023);
    wait_idle();
    write_window(REG_WIN_CH2, 6'd2);
    repeat (3) send_word(3'd2, 10'd1023);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [WIN_W-1:0]    wval;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
    int                  hot_ch;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_idle_on = (ph % 4) != 1 && (ph % 4) != 3;
      rx_idle_on = (ph % 4) != 2 && (ph % 4) != 3;
      for (int r = 0; r < NUM_WIN_REGS; r++) begin
        case (ph)
          0: wval = 6'd1;
          1: wval = 6'd32;
          2: wval = 6'd0;
          3: wval = 6'd63;
          default: begin
            case ($urandom_range(0, 5))
              0: wval = 6'd0;
              1: wval = WIN_W'($urandom_range(33, 63));
              default: wval = WIN_W'($urandom_range(1, 32));
            endcase
          end
        endcase
        write_window(win_reg_e'(r), wval);
      end
      write_window($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                   WIN_W'($urandom_range(0, 63)));
      hot_ch = $urandom_range(0, NUM_CHANNELS - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 9))
          0: ch = $urandom_range(0, 1) ? CH_UNUSED_6 : CH_UNUSED_7;
          1, 2, 3, 4: ch = CH_W'(hot_ch);
          default: ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        endcase
        case ($urandom_range(0, 9))
          0: smp = 10'd0;
          1: smp = 10'd1023;
          default: smp = SAMPLE_W'($urandom_range(0, 1023));
        endcase
        send_word(ch, smp);
      end
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    hold_pending = 1'b1;
    for (int n = 0; n < 24; n++) begin
      send_word(CH_W'($urandom_range(0, 7)), SAMPLE_W'($urandom_range(0, 1023)));
    end
    wait_idle();
  endtask

  // receiver: per word, optionally stall once it is offered; a pending hold stalls at once
  initial begin : rx_side
    int wait_n;
    out_stall_i = 1'b0;
    forever begin
      wait_n = hold_pending ? HOLD_CYCLES : (rx_idle_on ? $urandom_range(0, 6) : 0);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        if (hold_pending) begin
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_pending = 1'b0;
        end else begin
          do @(posedge clk_i); while (!out_valid_o);
          repeat (wait_n - 1) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin : check_words
    avg_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_avg_q.size() == 0) begin
        report_mismatch("output word with nothing expected, channel", out_channel_o, -1);
      end else begin
        want = expected_avg_q.pop_front();
        if (out_channel_o !== want.ch) begin
          report_mismatch("out_channel", out_channel_o, want.ch);
        end
        if (average_o !== want.avg) begin
          report_mismatch("average", average_o, want.avg);
        end
        if (accepted_o !== want.acc) begin
          report_mismatch("accepted", accepted_o, want.acc);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : run_tests
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    channel_i    = '0;
    sample_i     = '0;
    errors       = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_pending = 1'b0;
    for (int r = 0; r < NUM_WIN_REGS; r++) begin
      win_reg[r] = WIN_W'(WIN_RESET);
    end
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      ch_sum[ch] = 0;
      wr_ptr[ch] = 0;
      for (int s = 0; s < MAX_WINDOW; s++) begin
        hist[ch][s] = '0;
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_window_regs();
    test_window_shrink();
    test_random_traffic();
    test_backpressure();

    if (errors == 0 && expected_avg_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
